@@ rtl/efla_pkg.sv @@
`timescale 1ns / 1ps
package efla_pkg;

  localparam int unsigned DEF_HEAP_BYTES  = 65536;
  localparam int unsigned DEF_CHUNK_BYTES = 4096;

  localparam logic [31:0] SZ_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] MIN_BLK = 32'd16;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_IGN = 2'd2;

  typedef struct packed {
    logic        action;
    logic [16:0] req_size;
    logic [15:0] block_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } rsp_t;

endpackage

@@ rtl/explicit_free_list_allocator.sv @@
`timescale 1ns / 1ps
// Boundary-tag heap allocator, first fit over an address-ordered free list.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one request:
// allocate req_size bytes, or free the block whose payload is at block_addr.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
// item per request: payload offset and status.
// All heap words live in one RAM with one write port and one registered read
// port; each request is a sequence of header/footer/link read-modify-writes.
// A zero-size allocate goes straight to the output register with an ignore
// status. An allocate walks the free list, then takes the first block that
// fits, splitting it and inserting the remainder into the list when that is
// at least 16 bytes. A miss returns out of memory, else grows the heap, merges
// the new chunk with free neighbors, inserts it and takes it. A free walks the
// heap block by block, then merges with each free neighbor, unlinking it, and
// inserts the result. A list insert walks the list in address order.
// One request is processed at a time; the next is taken once the result is
// in the output register, even while the receiver still stalls it.
// After reset the RAM is loaded with the initial heap layout, one word per
// cycle; in_stall_o stays high during that pass.
// A stalled output item holds until it is taken; processing of a following
// request finishes but waits for the output register to drain.
module explicit_free_list_allocator
  import efla_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = DEF_HEAP_BYTES,
  parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned HW_DEPTH   = HEAP_BYTES / 4;
  localparam int unsigned IW         = $clog2(HW_DEPTH);
  localparam int unsigned WALK_LIMIT = HEAP_BYTES / 16 + 4;
  localparam int unsigned NW         = $clog2(WALK_LIMIT + 1);
  localparam int unsigned CHUNK_R    = (CHUNK_BYTES + 7) / 8 * 8;
  localparam int unsigned CHUNK_EXT  = (CHUNK_BYTES / 4 + (CHUNK_BYTES / 4) % 2) * 4;
  localparam logic [31:0] CHUNK_W    = 32'(CHUNK_BYTES);
  localparam logic [31:0] CHUNK_EXTW = 32'(CHUNK_EXT);
  localparam logic [31:0] HEAP_W     = 32'(HEAP_BYTES);
  localparam logic [31:0] BRK_RST    = 32'(16 + CHUNK_R);
  localparam logic [IW-1:0] IDX_HDR  = IW'(3);
  localparam logic [IW-1:0] IDX_FTR  = IW'((8 + CHUNK_R) / 4);
  localparam logic [IW-1:0] IDX_EPI  = IW'((12 + CHUNK_R) / 4);
  localparam logic [IW-1:0] IDX_LAST = IW'(HW_DEPTH - 1);
  localparam logic [NW-1:0] N_LIMIT  = NW'(WALK_LIMIT);

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_DONE,
    S_A_WALK, S_A_WSZ, S_A_WNX, S_A_MISS, S_A_G1, S_A_G2,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M4B, S_M5, S_M6, S_M6B, S_M7, S_M8, S_M9,
    S_C0, S_C1, S_C2, S_C3,
    S_I0, S_I_Z, S_I_W, S_I_W2, S_I_T1, S_I_T2, S_I_H1, S_I_H2,
    S_I_P1, S_I_P2, S_I_P3, S_I_P4,
    S_K0, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7,
    S_F_W, S_F_W2, S_F_G1
  } state_e;

  state_e      state_q, cret_q, iret_q;
  logic [IW-1:0] clr_q;
  logic        act_q;
  logic [31:0] addr_q, asize_q, ext_q, bp_q, size_q, prevp_q, nextp_q;
  logic [31:0] cx_q, pre_q, suc_q, cur_q, ib_q, found_q, brk_q, head_q;
  logic        pa_q;
  logic [NW-1:0] n_q;
  logic [15:0] res_q;
  logic [1:0]  stat_q;
  logic        out_valid_q;
  rsp_t        out_q;

  logic [31:0] mem_q [HW_DEPTH];
  logic [31:0] mem_rdata_q;
  logic        mem_we;
  logic [31:0] mem_wa, mem_wd, mem_ra;
  logic [IW-1:0] mem_widx, mem_ridx;
  logic [31:0] init_wd;

  logic [31:0] rsz, ext_c, asize_c;
  logic        split_c;

  assign rsz     = mem_rdata_q & SZ_MASK;
  assign ext_c   = (asize_q > CHUNK_W) ? asize_q : CHUNK_EXTW;
  assign asize_c = (in_data_i.req_size <= 17'd8) ? MIN_BLK
                 : ((32'(in_data_i.req_size) + 32'd15) & SZ_MASK);
  assign split_c = (size_q - asize_q) >= MIN_BLK;

  always_comb begin
    case (clr_q)
      IW'(1), IW'(2): init_wd = 32'd9;
      IDX_HDR, IDX_FTR: init_wd = 32'(CHUNK_R);
      IDX_EPI: init_wd = 32'd1;
      default: init_wd = '0;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state_q)
      S_A_WALK: mem_ra = bp_q - 32'd4;
      S_A_WSZ:  mem_ra = bp_q;
      S_A_MISS: begin
        mem_we = (brk_q + ext_c) <= HEAP_W;
        mem_wa = brk_q - 32'd4;
        mem_wd = ext_c;
      end
      S_A_G1: begin
        mem_we = 1'b1; mem_wa = brk_q + ext_q - 32'd8; mem_wd = ext_q;
      end
      S_A_G2: begin
        mem_we = 1'b1; mem_wa = brk_q + ext_q - 32'd4; mem_wd = 32'd1;
      end
      S_M0: mem_ra = bp_q - 32'd4;
      S_M1: mem_ra = bp_q - 32'd8;
      S_M2: mem_ra = bp_q + size_q - 32'd4;
      S_M4: mem_ra = nextp_q - 32'd4;
      S_M6: mem_ra = prevp_q - 32'd4;
      S_M7: begin
        mem_we = 1'b1; mem_wa = bp_q - 32'd4; mem_wd = size_q;
      end
      S_M8: begin
        mem_we = 1'b1; mem_wa = bp_q + size_q - 32'd8; mem_wd = size_q;
      end
      S_C0: mem_ra = cx_q + 32'd4;
      S_C1: mem_ra = cx_q;
      S_C2: begin
        if (pre_q == '0) begin
          mem_we = mem_rdata_q != '0;
          mem_wa = mem_rdata_q + 32'd4;
          mem_wd = '0;
        end else begin
          mem_we = 1'b1; mem_wa = pre_q; mem_wd = mem_rdata_q;
        end
      end
      S_C3: begin
        mem_we = suc_q != '0; mem_wa = suc_q + 32'd4; mem_wd = pre_q;
      end
      S_I0: begin
        mem_we = head_q == '0; mem_wa = ib_q; mem_wd = '0;
      end
      S_I_Z: begin
        mem_we = 1'b1; mem_wa = ib_q + 32'd4; mem_wd = '0;
      end
      S_I_W: begin
        if (cur_q < ib_q && n_q < N_LIMIT) begin
          mem_ra = cur_q;
        end else if (cur_q == head_q) begin
          mem_we = 1'b1; mem_wa = ib_q + 32'd4; mem_wd = '0;
        end else begin
          mem_ra = cur_q + 32'd4;
        end
      end
      S_I_W2: begin
        mem_we = mem_rdata_q == '0; mem_wa = cur_q; mem_wd = ib_q;
      end
      S_I_T1: begin
        mem_we = 1'b1; mem_wa = ib_q + 32'd4; mem_wd = cur_q;
      end
      S_I_T2: begin
        mem_we = 1'b1; mem_wa = ib_q; mem_wd = '0;
      end
      S_I_H1, S_I_P2: begin
        mem_we = 1'b1; mem_wa = ib_q; mem_wd = cur_q;
      end
      S_I_H2, S_I_P4: begin
        mem_we = 1'b1; mem_wa = cur_q + 32'd4; mem_wd = ib_q;
      end
      S_I_P1: begin
        mem_we = 1'b1; mem_wa = mem_rdata_q; mem_wd = ib_q;
      end
      S_I_P3: begin
        mem_we = 1'b1; mem_wa = ib_q + 32'd4; mem_wd = pre_q;
      end
      S_K0: mem_ra = found_q - 32'd4;
      S_K2: begin
        mem_we = 1'b1;
        mem_wa = found_q - 32'd4;
        mem_wd = split_c ? (asize_q | 32'd1) : (size_q | 32'd1);
      end
      S_K3: begin
        mem_we = 1'b1; mem_wa = found_q + asize_q - 32'd8; mem_wd = asize_q | 32'd1;
      end
      S_K4: begin
        mem_we = 1'b1; mem_wa = found_q + asize_q - 32'd4; mem_wd = size_q - asize_q;
      end
      S_K5: begin
        mem_we = 1'b1; mem_wa = found_q + size_q - 32'd8; mem_wd = size_q - asize_q;
      end
      S_K7: begin
        mem_we = 1'b1; mem_wa = found_q + size_q - 32'd8; mem_wd = size_q | 32'd1;
      end
      S_F_W: mem_ra = cur_q - 32'd4;
      S_F_W2: begin
        mem_we = (rsz != '0) && (cur_q == addr_q) && mem_rdata_q[0];
        mem_wa = addr_q - 32'd4;
        mem_wd = rsz;
      end
      S_F_G1: begin
        mem_we = 1'b1; mem_wa = addr_q + size_q - 32'd8; mem_wd = size_q;
      end
      default: ;
    endcase
  end

  assign mem_widx = (state_q == S_INIT) ? clr_q : mem_wa[IW+1:2];
  assign mem_ridx = mem_ra[IW+1:2];

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      mem_q[mem_widx] <= init_wd;
    end else if (mem_we) begin
      mem_q[mem_widx] <= mem_wd;
    end
    mem_rdata_q <= mem_q[mem_ridx];
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cret_q      <= S_IDLE;
      iret_q      <= S_IDLE;
      clr_q       <= '0;
      brk_q       <= BRK_RST;
      head_q      <= 32'd16;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      // S_DONE handles its own drain and reload
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == IDX_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            act_q  <= in_data_i.action;
            addr_q <= 32'(in_data_i.block_addr);
            asize_q <= asize_c;
            res_q  <= '0;
            stat_q <= ST_OK;
            bp_q   <= head_q;
            cur_q  <= 32'd16;
            n_q    <= '0;
            if (in_data_i.action == ACT_FREE) begin
              state_q <= S_F_W;
            end else if (in_data_i.req_size == '0) begin
              stat_q  <= ST_IGN;
              state_q <= S_DONE;
            end else begin
              state_q <= S_A_WALK;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.payload_addr <= res_q;
            out_q.status       <= stat_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        S_A_WALK: begin
          state_q <= (bp_q == '0 || n_q >= N_LIMIT) ? S_A_MISS : S_A_WSZ;
        end
        S_A_WSZ: begin
          if (rsz >= asize_q) begin
            found_q <= bp_q;
            state_q <= S_K0;
          end else begin
            state_q <= S_A_WNX;
          end
        end
        S_A_WNX: begin
          bp_q    <= mem_rdata_q;
          n_q     <= n_q + NW'(1);
          state_q <= S_A_WALK;
        end
        S_A_MISS: begin
          ext_q <= ext_c;
          if ((brk_q + ext_c) > HEAP_W) begin
            stat_q  <= ST_OOM;
            state_q <= S_DONE;
          end else begin
            state_q <= S_A_G1;
          end
        end
        S_A_G1: state_q <= S_A_G2;
        S_A_G2: begin
          bp_q    <= brk_q;
          brk_q   <= brk_q + ext_q;
          state_q <= S_M0;
        end
        S_M0: state_q <= S_M1;
        S_M1: begin
          size_q  <= rsz;
          state_q <= S_M2;
        end
        S_M2: begin
          pa_q    <= mem_rdata_q[0];
          prevp_q <= bp_q - rsz;
          nextp_q <= bp_q + size_q;
          state_q <= S_M3;
        end
        S_M3: begin
          if (!mem_rdata_q[0]) begin
            cx_q    <= nextp_q;
            cret_q  <= S_M4;
            state_q <= S_C0;
          end else begin
            state_q <= S_M5;
          end
        end
        S_M4: state_q <= S_M4B;
        S_M4B: begin
          size_q  <= size_q + rsz;
          state_q <= S_M5;
        end
        S_M5: begin
          if (!pa_q) begin
            cx_q    <= prevp_q;
            cret_q  <= S_M6;
            state_q <= S_C0;
          end else begin
            state_q <= S_M7;
          end
        end
        S_M6: state_q <= S_M6B;
        S_M6B: begin
          size_q  <= size_q + rsz;
          bp_q    <= prevp_q;
          state_q <= S_M7;
        end
        S_M7: state_q <= S_M8;
        S_M8: begin
          ib_q    <= bp_q;
          iret_q  <= S_M9;
          state_q <= S_I0;
        end
        S_M9: begin
          if (act_q == ACT_FREE) begin
            state_q <= S_DONE;
          end else begin
            found_q <= bp_q;
            state_q <= S_K0;
          end
        end
        S_C0: state_q <= S_C1;
        S_C1: begin
          pre_q   <= mem_rdata_q;
          state_q <= S_C2;
        end
        S_C2: begin
          suc_q <= mem_rdata_q;
          if (pre_q == '0) begin
            head_q  <= mem_rdata_q;
            state_q <= cret_q;
          end else begin
            state_q <= S_C3;
          end
        end
        S_C3: state_q <= cret_q;
        S_I0: begin
          cur_q <= head_q;
          n_q   <= '0;
          if (head_q == '0) begin
            head_q  <= ib_q;
            state_q <= S_I_Z;
          end else begin
            state_q <= S_I_W;
          end
        end
        S_I_Z: state_q <= iret_q;
        S_I_W: begin
          if (cur_q < ib_q && n_q < N_LIMIT) begin
            state_q <= S_I_W2;
          end else if (cur_q == head_q) begin
            state_q <= S_I_H1;
          end else begin
            state_q <= S_I_P1;
          end
        end
        S_I_W2: begin
          if (mem_rdata_q == '0) begin
            state_q <= S_I_T1;
          end else begin
            cur_q   <= mem_rdata_q;
            n_q     <= n_q + NW'(1);
            state_q <= S_I_W;
          end
        end
        S_I_T1: state_q <= S_I_T2;
        S_I_T2: state_q <= iret_q;
        S_I_H1: state_q <= S_I_H2;
        S_I_H2: begin
          head_q  <= ib_q;
          state_q <= iret_q;
        end
        S_I_P1: begin
          pre_q   <= mem_rdata_q;
          state_q <= S_I_P2;
        end
        S_I_P2: state_q <= S_I_P3;
        S_I_P3: state_q <= S_I_P4;
        S_I_P4: state_q <= iret_q;
        S_K0: state_q <= S_K1;
        S_K1: begin
          size_q  <= rsz;
          cx_q    <= found_q;
          cret_q  <= S_K2;
          state_q <= S_C0;
        end
        S_K2: state_q <= split_c ? S_K3 : S_K7;
        S_K3: state_q <= S_K4;
        S_K4: state_q <= S_K5;
        S_K5: begin
          ib_q    <= found_q + asize_q;
          iret_q  <= S_K6;
          state_q <= S_I0;
        end
        S_K7: state_q <= S_K6;
        S_K6: begin
          res_q   <= found_q[15:0];
          state_q <= S_DONE;
        end
        S_F_W: begin
          if (cur_q < brk_q && n_q < N_LIMIT) begin
            state_q <= S_F_W2;
          end else begin
            stat_q  <= ST_IGN;
            state_q <= S_DONE;
          end
        end
        S_F_W2: begin
          if (rsz == '0 || cur_q > addr_q) begin
            stat_q  <= ST_IGN;
            state_q <= S_DONE;
          end else if (cur_q == addr_q) begin
            if (mem_rdata_q[0]) begin
              size_q  <= rsz;
              state_q <= S_F_G1;
            end else begin
              stat_q  <= ST_IGN;
              state_q <= S_DONE;
            end
          end else begin
            cur_q   <= cur_q + rsz;
            n_q     <= n_q + NW'(1);
            state_q <= S_F_W;
          end
        end
        S_F_G1: begin
          bp_q    <= addr_q;
          state_q <= S_M0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
